>>> hw/rtl/spsm_pkg.sv
// Shared types and constants for the slotted page space manager.
`timescale 1ns / 1ps

package spsm_pkg;

  // Fixed field widths of the request and result
  localparam int OP_W   = 2;
  localparam int SLOT_W = 10;
  localparam int SIZE_W = 13;
  localparam int PAGE_W = 32;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [PAGE_W-1:0] page_t;

  // Request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, launch slot read
    logic commit;   // load result, update page state
  } ctl_cmd_t;

endpackage

>>> hw/rtl/spsm_ctrl.sv
// Request sequencer: handshakes and the two-step request flow.
`timescale 1ns / 1ps

module spsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output spsm_pkg::ctl_cmd_t cmd
);
  import spsm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, commit;

  // Output register is free when empty or being drained this cycle
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign cmd.capture = accept;
  assign cmd.commit  = commit;
  assign out_valid   = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/spsm_datapath.sv
// Page state, slot directory memories and result computation.
`timescale 1ns / 1ps

module spsm_datapath #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int SLOT_BYTES   = 8,
  parameter int MAX_SLOTS    = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  spsm_pkg::ctl_cmd_t cmd,
  input  logic [1:0]         in_operation,
  input  spsm_pkg::slot_t    in_slot_index,
  input  spsm_pkg::size_t    in_record_size,
  input  logic               cfg_wr_en,
  input  spsm_pkg::page_t    cfg_wr_data,
  output logic               out_success,
  output spsm_pkg::slot_t    out_assigned_slot,
  output spsm_pkg::size_t    out_data_offset,
  output spsm_pkg::size_t    out_record_length,
  output spsm_pkg::page_t    out_record_page
);
  import spsm_pkg::*;

  localparam int FP_W    = $clog2(PAGE_BYTES + 1);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int IDX_W   = $clog2(MAX_SLOTS);
  localparam int REQ_MAX = HEADER_BYTES + (MAX_SLOTS + 1) * SLOT_BYTES + (1 << SIZE_W) - 1;
  localparam int CMP_MAX = (REQ_MAX > PAGE_BYTES) ? REQ_MAX : PAGE_BYTES;
  localparam int CMP_W   = $clog2(CMP_MAX + 1);
  localparam int SX_W    = SLOT_W + 1;

  typedef logic [FP_W-1:0]  fp_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CMP_W-1:0] cmp_t;
  typedef logic [SX_W-1:0]  sx_t;

  // Page header state
  fp_t   fp_r;
  cnt_t  count_r;
  page_t page_r;

  // Latched request and registered slot read
  op_t   req_op_r;
  slot_t req_slot_r;
  size_t req_size_r;
  fp_t   rd_off_r;
  size_t rd_size_r;

  // Slot directory
  fp_t   off_mem [MAX_SLOTS];
  size_t size_mem [MAX_SLOTS];

  // Result registers
  logic  res_ok_r;
  slot_t res_slot_r;
  size_t res_off_r;
  size_t res_len_r;
  page_t res_page_r;

  logic  full, fits, in_range, live, ins_ok;
  cmp_t  req_bytes;
  fp_t   fp_new;
  logic  ok_c;
  slot_t slot_c;
  size_t off_c, len_c;
  logic  off_we, size_we;
  idx_t  wr_idx;
  size_t size_wd;

  // Insert fit check: header + directory with one more slot + record
  assign req_bytes = cmp_t'(HEADER_BYTES)
                   + cmp_t'(count_r + 1'b1) * cmp_t'(SLOT_BYTES)
                   + cmp_t'(req_size_r);
  assign fits     = !(cmp_t'(fp_r) < req_bytes);
  assign full     = (count_r == cnt_t'(MAX_SLOTS));
  assign ins_ok   = !full && fits;
  assign fp_new   = fp_r - fp_t'(req_size_r);
  assign in_range = sx_t'(req_slot_r) < sx_t'(count_r);
  assign live     = (rd_size_r != '0);

  // Result per operation
  always_comb begin
    ok_c   = 1'b0;
    slot_c = req_slot_r;
    off_c  = '0;
    len_c  = '0;
    case (req_op_r)
      OP_INSERT: begin
        ok_c   = ins_ok;
        slot_c = slot_t'(count_r);
        if (ins_ok) begin
          off_c = size_t'(fp_new);
          len_c = req_size_r;
        end
      end
      OP_GET: begin
        ok_c = in_range && live;
        if (ok_c) begin
          off_c = size_t'(rd_off_r);
          len_c = rd_size_r;
        end
      end
      OP_DELETE: begin
        ok_c = in_range;
        if (in_range) off_c = size_t'(rd_off_r);
      end
      OP_UPDATE: begin
        ok_c = in_range && live && (rd_size_r == req_size_r);
        if (ok_c) begin
          off_c = size_t'(rd_off_r);
          len_c = req_size_r;
        end
      end
      default: ok_c = 1'b0;
    endcase
  end

  // Directory write controls
  assign off_we  = cmd.commit && (req_op_r == OP_INSERT) && ins_ok;
  assign size_we = off_we || (cmd.commit && (req_op_r == OP_DELETE) && in_range);
  assign wr_idx  = (req_op_r == OP_INSERT) ? idx_t'(count_r) : req_slot_r[IDX_W-1:0];
  assign size_wd = (req_op_r == OP_INSERT) ? req_size_r : '0;

  // Slot directory memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (off_we) off_mem[wr_idx] <= fp_new;
    if (size_we) size_mem[wr_idx] <= size_wd;
    if (cmd.capture) begin
      rd_off_r  <= off_mem[in_slot_index[IDX_W-1:0]];
      rd_size_r <= size_mem[in_slot_index[IDX_W-1:0]];
    end
  end

  // Request latch and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op_r   <= op_t'(in_operation);
      req_slot_r <= in_slot_index;
      req_size_r <= in_record_size;
    end
    if (cmd.commit) begin
      res_ok_r   <= ok_c;
      res_slot_r <= slot_c;
      res_off_r  <= off_c;
      res_len_r  <= len_c;
      res_page_r <= page_r;
    end
  end

  // Free pointer, record count and page number
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r    <= fp_t'(PAGE_BYTES);
      count_r <= '0;
      page_r  <= '0;
    end else begin
      if (off_we) begin
        fp_r    <= fp_new;
        count_r <= count_r + 1'b1;
      end
      if (cfg_wr_en) page_r <= cfg_wr_data;
    end
  end

  assign out_success       = res_ok_r;
  assign out_assigned_slot = res_slot_r;
  assign out_data_offset   = res_off_r;
  assign out_record_length = res_len_r;
  assign out_record_page   = res_page_r;

endmodule

>>> hw/rtl/slotted_page_space_manager.sv
// Slotted page space manager: sequencer plus slot directory datapath.
//
// Keeps the free pointer, record count and slot directory of one page.
// Input requests (insert, get, delete, update) arrive on a valid/ready
// channel; each produces exactly one result on the out_ valid/ready channel.
// cfg_wr_en/cfg_wr_data set the page number returned with every result;
// write it only while no request is in flight.
// Timing: a request is taken when in_ready is high and the slot directory is
// read at that same edge; the result is registered in the execute step once
// the output register is free, and out_valid rises with it. One request is
// in flight at a time: the next is taken only after the previous one commits,
// as the registered slot directory read is followed by its write-back.
// A result waiting in the output register does not block the next request;
// if the receiver stalls, the following request waits in the execute step
// until the output register frees up, and in_ready stays low meanwhile.
// Reset: free pointer to PAGE_BYTES, record count and page number to zero.
// The directory needs no clearing; only entries below the count are used.
`timescale 1ns / 1ps

module slotted_page_space_manager #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int SLOT_BYTES   = 8,
  parameter int MAX_SLOTS    = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      in_operation,
  input  spsm_pkg::slot_t in_slot_index,
  input  spsm_pkg::size_t in_record_size,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_success,
  output spsm_pkg::slot_t out_assigned_slot,
  output spsm_pkg::size_t out_data_offset,
  output spsm_pkg::size_t out_record_length,
  output spsm_pkg::page_t out_record_page,
  input  logic            cfg_wr_en,
  input  spsm_pkg::page_t cfg_wr_data
);
  import spsm_pkg::*;

  ctl_cmd_t cmd;

  spsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spsm_datapath #(
    .PAGE_BYTES   (PAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .SLOT_BYTES   (SLOT_BYTES),
    .MAX_SLOTS    (MAX_SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_slot_index     (in_slot_index),
    .in_record_size    (in_record_size),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_success       (out_success),
    .out_assigned_slot (out_assigned_slot),
    .out_data_offset   (out_data_offset),
    .out_record_length (out_record_length),
    .out_record_page   (out_record_page)
  );

endmodule

>>> bench/spsm_checker.sv
// Result checker for the slotted page space manager: tracks page state and compares results.
`timescale 1ns / 1ps

module spsm_checker #(
  parameter int PAGE_BYTES   = 4096,
  parameter int HEADER_BYTES = 24,
  parameter int SLOT_BYTES   = 8,
  parameter int MAX_SLOTS    = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [1:0]      in_operation,
  input  spsm_pkg::slot_t in_slot_index,
  input  spsm_pkg::size_t in_record_size,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic            out_success,
  input  spsm_pkg::slot_t out_assigned_slot,
  input  spsm_pkg::size_t out_data_offset,
  input  spsm_pkg::size_t out_record_length,
  input  spsm_pkg::page_t out_record_page,
  input  logic            cfg_wr_en,
  input  spsm_pkg::page_t cfg_wr_data,
  output int              fail_count,
  output int              pending_results
);
  import spsm_pkg::*;

  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic  success;
    slot_t slot;
    size_t offset;
    size_t length;
    page_t page;
  } page_result_t;

  // Page bookkeeping as the block should hold it
  page_t page_number;
  int    free_ptr;
  int    slot_count;
  size_t slot_offsets [MAX_SLOTS];
  size_t slot_lengths [MAX_SLOTS];

  page_result_t expected_results[$];

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  // Apply one request to the page state and return the result it should give
  function automatic page_result_t apply_request(op_t op, slot_t slot, size_t size);
    page_result_t r;
    int           need;
    r.success = 1'b0;
    r.slot    = slot;
    r.offset  = '0;
    r.length  = '0;
    r.page    = page_number;
    if (op == OP_INSERT) begin
      need   = HEADER_BYTES + (slot_count + 1) * SLOT_BYTES + int'(size);
      r.slot = slot_t'(slot_count);
      if (slot_count < MAX_SLOTS && free_ptr >= need) begin
        free_ptr -= int'(size);
        slot_offsets[slot_count] = size_t'(free_ptr);
        slot_lengths[slot_count] = size;
        r.success  = 1'b1;
        r.offset   = size_t'(free_ptr);
        r.length   = size;
        slot_count++;
      end
    end else if (int'(slot) < slot_count && int'(slot) < MAX_SLOTS) begin
      case (op)
        OP_GET: begin
          if (slot_lengths[slot] != 0) begin
            r.success = 1'b1;
            r.offset  = slot_offsets[slot];
            r.length  = slot_lengths[slot];
          end
        end
        OP_DELETE: begin
          // delete always succeeds in range, even on a dead slot
          slot_lengths[slot] = '0;
          r.success = 1'b1;
          r.offset  = slot_offsets[slot];
        end
        OP_UPDATE: begin
          // state untouched; only a live slot of equal size passes
          if (slot_lengths[slot] != 0 && slot_lengths[slot] == size) begin
            r.success = 1'b1;
            r.offset  = slot_offsets[slot];
            r.length  = size;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (fail_count < MAX_REPORTS)
      $display("%0t ns: MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    page_result_t want;
    if (!rst_n) begin
      page_number = '0;
      free_ptr    = PAGE_BYTES;
      slot_count  = 0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en)
        page_number = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", out_assigned_slot, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_success !== want.success)
            report_mismatch("success", out_success, want.success);
          if (out_assigned_slot !== want.slot)
            report_mismatch("assigned_slot", out_assigned_slot, want.slot);
          if (out_data_offset !== want.offset)
            report_mismatch("data_offset", out_data_offset, want.offset);
          if (out_record_length !== want.length)
            report_mismatch("record_length", out_record_length, want.length);
          if (out_record_page !== want.page)
            report_mismatch("record_page", out_record_page, want.page);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(
          apply_request(op_t'(in_operation), in_slot_index, in_record_size));
    end
    pending_results <= expected_results.size();
  end

endmodule

>>> bench/slotted_page_space_manager_tb.sv
// Testbench top for the slotted page space manager: clock, reset, requests, verdict.
`timescale 1ns / 1ps

module slotted_page_space_manager_tb;
  import spsm_pkg::*;

  localparam int PAGE_BYTES     = 4096;
  localparam int HEADER_BYTES   = 24;
  localparam int SLOT_BYTES     = 8;
  localparam int MAX_SLOTS      = 512;
  localparam int RANDOM_ITEMS   = 260;
  localparam int SETTLE_CYCLES  = 6;
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk               = 1'b0;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation      = OP_GET;
  slot_t       in_slot_index     = '0;
  size_t       in_record_size    = '0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic        out_success;
  slot_t       out_assigned_slot;
  size_t       out_data_offset;
  size_t       out_record_length;
  page_t       out_record_page;
  logic        cfg_wr_en         = 1'b0;
  page_t       cfg_wr_data       = '0;

  int checker_failures;
  int results_pending;
  int send_idle_pct = 38;
  int recv_idle_pct = 73;
  int idle_cycles   = 0;

  // Stimulus-side view of the page, used only to aim slot indices, updates and fills
  int    room_left = PAGE_BYTES;
  size_t inserted_sizes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  slotted_page_space_manager #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .SLOT_BYTES  (SLOT_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .in_record_size   (in_record_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_success      (out_success),
    .out_assigned_slot(out_assigned_slot),
    .out_data_offset  (out_data_offset),
    .out_record_length(out_record_length),
    .out_record_page  (out_record_page),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  spsm_checker #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .SLOT_BYTES  (SLOT_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_slot_index    (in_slot_index),
    .in_record_size   (in_record_size),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_success      (out_success),
    .out_assigned_slot(out_assigned_slot),
    .out_data_offset  (out_data_offset),
    .out_record_length(out_record_length),
    .out_record_page  (out_record_page),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .fail_count       (checker_failures),
    .pending_results  (results_pending)
  );

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: no request or result moving for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("slotted_page_space_manager test failed");
      $finish;
    end
  end

  // Drive one request and hold it until taken
  task automatic send_request(op_t op, slot_t slot, size_t size);
    int need;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_slot_index  <= slot;
    in_record_size <= size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_INSERT) begin
      need = HEADER_BYTES + (inserted_sizes.size() + 1) * SLOT_BYTES + int'(size);
      if (inserted_sizes.size() < MAX_SLOTS && room_left >= need) begin
        room_left -= int'(size);
        inserted_sizes.push_back(size);
      end
    end
  endtask

  // Mostly sizes that keep the page filling slowly; updates aim at real sizes
  task automatic random_request();
    int    pick;
    int    n;
    op_t   op;
    slot_t slot;
    size_t size;
    n    = inserted_sizes.size();
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_INSERT;
    else if (pick < 62) op = OP_GET;
    else if (pick < 68) op = OP_DELETE;
    else                op = OP_UPDATE;
    if (n > 0 && $urandom_range(0, 99) < 85)
      slot = slot_t'($urandom_range(0, n - 1));
    else
      slot = slot_t'($urandom_range(0, 1023));
    pick = $urandom_range(0, 99);
    if (pick < 90)      size = size_t'($urandom_range(0, 24));
    else if (pick < 98) size = size_t'($urandom_range(25, 200));
    else                size = size_t'($urandom_range(201, 4096));
    if (op == OP_UPDATE && int'(slot) < n && $urandom_range(0, 3) != 0)
      size = inserted_sizes[slot];
    send_request(op, slot, size);
  endtask

  // Drop valid, then wait for every result plus the settle period
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_page_number(page_t value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    int gap;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty page, zero-size slot, oversize inserts, live/dead slots
    send_request(OP_GET,    10'd0,    13'd0);
    send_request(OP_UPDATE, 10'd0,    13'd0);
    send_request(OP_DELETE, 10'd0,    13'd0);
    send_request(OP_INSERT, 10'd0,    13'd0);
    send_request(OP_GET,    10'd0,    13'd0);
    send_request(OP_UPDATE, 10'd0,    13'd0);
    send_request(OP_INSERT, 10'd1023, 13'd4096);
    send_request(OP_INSERT, 10'd0,    13'd4095);
    send_request(OP_INSERT, 10'd0,    13'd100);
    send_request(OP_INSERT, 10'd0,    13'd1);
    send_request(OP_GET,    10'd1,    13'd0);
    send_request(OP_UPDATE, 10'd1,    13'd100);
    send_request(OP_UPDATE, 10'd1,    13'd101);
    send_request(OP_DELETE, 10'd1,    13'd0);
    send_request(OP_DELETE, 10'd1,    13'd0);
    send_request(OP_GET,    10'd1,    13'd0);
    send_request(OP_UPDATE, 10'd1,    13'd100);
    send_request(OP_GET,    10'd1023, 13'd0);
    send_request(OP_DELETE, 10'd1023, 13'd0);
    send_request(OP_UPDATE, 10'd1023, 13'd4096);
    send_request(OP_GET,    10'd2,    13'd0);
    wait_idle();
    write_page_number(32'hFFFF_FFFF);

    // Random phases with changing idle patterns and page numbers
    repeat (RANDOM_ITEMS) random_request();
    wait_idle();
    write_page_number(page_t'($urandom));
    send_idle_pct = 73;
    recv_idle_pct = 38;
    repeat (RANDOM_ITEMS) random_request();
    wait_idle();
    write_page_number('0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_ITEMS) random_request();

    // Fill the page to the last byte, then one more insert that must be refused
    gap = room_left - (HEADER_BYTES + (inserted_sizes.size() + 1) * SLOT_BYTES);
    if (inserted_sizes.size() < MAX_SLOTS && gap >= 0)
      send_request(OP_INSERT, 10'd0, size_t'(gap));
    send_request(OP_INSERT, 10'd0, 13'd0);
    if (inserted_sizes.size() > 0)
      send_request(OP_GET, slot_t'(inserted_sizes.size() - 1), 13'd0);
    wait_idle();

    if (checker_failures == 0)
      $display("slotted_page_space_manager test passed");
    else
      $display("slotted_page_space_manager test failed");
    $finish;
  end

endmodule
